>>> rtl/pcw_pkg.sv
// Package for the PNG chunk walker: phase codes, result codes, signature and type tables.
`timescale 1ns / 1ps
package pcw_pkg;

    // Parser phases
    localparam logic [2:0] PH_SIG  = 3'd0;
    localparam logic [2:0] PH_LEN  = 3'd1;
    localparam logic [2:0] PH_TYPE = 3'd2;
    localparam logic [2:0] PH_SKIP = 3'd3;
    localparam logic [2:0] PH_STOP = 3'd4;

    // Chunk kinds
    localparam logic [4:0] KIND_IHDR = 5'd0;
    localparam logic [4:0] KIND_IEND = 5'd1;
    localparam logic [4:0] KIND_IDAT = 5'd2;
    localparam logic [4:0] KIND_PLTE = 5'd3;
    localparam logic [4:0] KIND_BKGD = 5'd4;
    localparam logic [4:0] KIND_CHRM = 5'd5;
    localparam logic [4:0] KIND_GAMA = 5'd6;
    localparam logic [4:0] KIND_ICCP = 5'd7;
    localparam logic [4:0] KIND_SBIT = 5'd8;
    localparam logic [4:0] KIND_SRGB = 5'd9;
    localparam logic [4:0] KIND_HIST = 5'd10;
    localparam logic [4:0] KIND_TRNS = 5'd11;
    localparam logic [4:0] KIND_PHYS = 5'd12;
    localparam logic [4:0] KIND_SPLT = 5'd13;
    localparam logic [4:0] KIND_TIME = 5'd14;
    localparam logic [4:0] KIND_ITXT = 5'd15;
    localparam logic [4:0] KIND_TEXT = 5'd16;
    localparam logic [4:0] KIND_ZTXT = 5'd17;
    localparam logic [4:0] KIND_NONE = 5'd31;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_SIG   = 3'd1;
    localparam logic [2:0] ST_UNKNOWN   = 3'd2;
    localparam logic [2:0] ST_NOT_IHDR  = 3'd3;
    localparam logic [2:0] ST_DUP_BKGD  = 3'd4;

    // Length of the chunk trailer (CRC) that follows the data
    localparam logic [32:0] CRC_BYTES = 33'd4;

    // Depth of the queue between parser and output stage
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] length;
        logic [2:0]  status;
    } t_result;

    // Expected signature byte at each position
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'd137;
            3'd1:    b = 8'd80;
            3'd2:    b = 8'd78;
            3'd3:    b = 8'd71;
            3'd4:    b = 8'd13;
            3'd5:    b = 8'd10;
            3'd6:    b = 8'd26;
            3'd7:    b = 8'd10;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    // Map a four-character type tag to its kind, KIND_NONE if unknown
    function automatic logic [4:0] classify(input logic [31:0] tag);
        logic [4:0] k;
        case (tag)
            "IHDR":  k = KIND_IHDR;
            "IEND":  k = KIND_IEND;
            "IDAT":  k = KIND_IDAT;
            "PLTE":  k = KIND_PLTE;
            "bKGD":  k = KIND_BKGD;
            "cHRM":  k = KIND_CHRM;
            "gAMA":  k = KIND_GAMA;
            "iCCP":  k = KIND_ICCP;
            "sBIT":  k = KIND_SBIT;
            "sRGB":  k = KIND_SRGB;
            "hIST":  k = KIND_HIST;
            "tRNS":  k = KIND_TRNS;
            "pHYs":  k = KIND_PHYS;
            "sPLT":  k = KIND_SPLT;
            "tIME":  k = KIND_TIME;
            "iTXt":  k = KIND_ITXT;
            "tEXt":  k = KIND_TEXT;
            "zTXt":  k = KIND_ZTXT;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

>>> rtl/pcw_front.sv
// Front end: accepts input bytes, frames signature and chunks, classifies chunk types.
`timescale 1ns / 1ps
module pcw_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_data_byte,
    input  logic            i_new_file,
    input  logic            i_queue_full,
    output logic            o_push,
    output pcw_pkg::t_result o_rec
);
    import pcw_pkg::*;

    logic [2:0]  r_phase, n_phase;
    logic [2:0]  r_idx, n_idx;
    logic [31:0] r_len, n_len;
    logic [31:0] r_type, n_type;
    logic [32:0] r_skip, n_skip;
    logic        r_any, n_any;
    logic        r_bkgd, n_bkgd;

    logic [2:0]  e_phase;
    logic [2:0]  e_idx;
    logic [31:0] e_len;
    logic [31:0] e_type;
    logic [32:0] e_skip;
    logic        e_any;
    logic        e_bkgd;
    logic [31:0] tag;
    logic [4:0]  kind;
    logic [32:0] skip_dec;
    logic        accept;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;

    // A new file restarts from the reset state before this byte is parsed
    always_comb begin
        e_phase = i_new_file ? PH_SIG : r_phase;
        e_idx   = i_new_file ? 3'd0   : r_idx;
        e_len   = i_new_file ? 32'd0  : r_len;
        e_type  = i_new_file ? 32'd0  : r_type;
        e_skip  = i_new_file ? 33'd0  : r_skip;
        e_any   = i_new_file ? 1'b0   : r_any;
        e_bkgd  = i_new_file ? 1'b0   : r_bkgd;
    end

    assign tag      = {e_type[23:0], i_data_byte};
    assign kind     = classify(tag);
    assign skip_dec = (e_skip != 33'd0) ? (e_skip - 33'd1) : e_skip;

    // Per-byte parse step
    always_comb begin
        n_phase = e_phase;
        n_idx   = e_idx;
        n_len   = e_len;
        n_type  = e_type;
        n_skip  = e_skip;
        n_any   = e_any;
        n_bkgd  = e_bkgd;
        o_push  = 1'b0;
        o_rec   = '{kind: KIND_IHDR, length: e_len, status: ST_OK};
        case (e_phase)
            PH_SIG: begin
                if (i_data_byte != sig_byte(e_idx)) begin
                    n_phase = PH_STOP;
                    o_push  = accept;
                    o_rec   = '{kind: KIND_IHDR, length: 32'd0, status: ST_BAD_SIG};
                end else if (e_idx == 3'd7) begin
                    n_phase = PH_LEN;
                    n_idx   = 3'd0;
                    n_len   = 32'd0;
                end else begin
                    n_idx = e_idx + 3'd1;
                end
            end
            PH_LEN: begin
                n_len = {e_len[23:0], i_data_byte};
                if (e_idx == 3'd3) begin
                    n_phase = PH_TYPE;
                    n_idx   = 3'd0;
                    n_type  = 32'd0;
                end else begin
                    n_idx = e_idx + 3'd1;
                end
            end
            PH_TYPE: begin
                n_type = tag;
                if (e_idx < 3'd3) begin
                    n_idx = e_idx + 3'd1;
                end else begin
                    n_idx  = 3'd0;
                    o_push = accept;
                    if (kind == KIND_NONE) begin
                        n_phase = PH_STOP;
                        o_rec   = '{kind: KIND_IHDR, length: e_len, status: ST_UNKNOWN};
                    end else if (!e_any && kind != KIND_IHDR) begin
                        n_phase = PH_STOP;
                        o_rec   = '{kind: kind, length: e_len, status: ST_NOT_IHDR};
                    end else if (kind == KIND_BKGD && e_bkgd) begin
                        n_any   = 1'b1;
                        n_phase = PH_STOP;
                        o_rec   = '{kind: kind, length: e_len, status: ST_DUP_BKGD};
                    end else begin
                        n_any = 1'b1;
                        o_rec = '{kind: kind, length: e_len, status: ST_OK};
                        if (kind == KIND_BKGD) begin
                            n_bkgd = 1'b1;
                        end
                        if (kind == KIND_IEND) begin
                            n_phase = PH_STOP;
                        end else begin
                            n_skip  = {1'b0, e_len} + CRC_BYTES;
                            n_phase = PH_SKIP;
                        end
                    end
                end
            end
            PH_SKIP: begin
                n_skip = skip_dec;
                if (skip_dec == 33'd0) begin
                    n_phase = PH_LEN;
                    n_idx   = 3'd0;
                    n_len   = 32'd0;
                end
            end
            default: begin
                // stopped: bytes are dropped until a new file starts
            end
        endcase
    end

    // State registers advance on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIG;
            r_idx   <= 3'd0;
            r_len   <= 32'd0;
            r_type  <= 32'd0;
            r_skip  <= 33'd0;
            r_any   <= 1'b0;
            r_bkgd  <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_len   <= n_len;
            r_type  <= n_type;
            r_skip  <= n_skip;
            r_any   <= n_any;
            r_bkgd  <= n_bkgd;
        end
    end

endmodule

>>> rtl/pcw_queue.sv
// Short result queue between the parser front end and the output stage.
`timescale 1ns / 1ps
module pcw_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pcw_pkg::t_result i_rec,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output pcw_pkg::t_result o_rec
);
    import pcw_pkg::*;

    localparam int PtrW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    t_result         r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            do_pop;

    assign o_full  = (r_count == CntW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/pcw_back.sv
// Back end: output register that presents one result word to the receiver.
`timescale 1ns / 1ps
module pcw_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  pcw_pkg::t_result i_q_rec,
    output logic             o_q_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [4:0]       o_chunk_kind,
    output logic [31:0]      o_chunk_length,
    output logic [2:0]       o_status
);
    import pcw_pkg::*;

    logic    r_valid;
    t_result r_rec;

    // Load when empty or when the current word leaves this cycle
    assign o_q_pop = i_q_valid && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rec <= i_q_rec;
        end
    end

    assign o_valid        = r_valid;
    assign o_chunk_kind   = r_rec.kind;
    assign o_chunk_length = r_rec.length;
    assign o_status       = r_rec.status;

endmodule

>>> rtl/png_chunk_walker_top.sv
// PNG chunk walker: byte-serial signature check and chunk framer.
// Input channel: one file byte per word (i_data_byte) with i_new_file marking
// the first signature byte of a new file; accepted when i_valid && o_ready.
// Output channel: one word per classified chunk type or error, carrying
// o_chunk_kind, o_chunk_length and o_status; taken when o_valid && i_ready.
// Throughput: one byte per cycle while the queue is not full. Each byte is parsed
// in the cycle it is accepted; the parser state update is the only loop.
// A result passes through the two-entry queue and then the output register
// before it is visible on the output channel.
// Most bytes produce no result; only the fourth type byte of a chunk or a
// signature mismatch does. Errors and IEND stop the walk until i_new_file.
// Reset (i_rst_n low, synchronous) empties queue and output register and puts
// the parser in the signature phase.
// Receiver stall: results wait in the output register and queue; o_ready drops
// only when the queue holds two results, so input flows while the
// output side stalls briefly.
`timescale 1ns / 1ps
module png_chunk_walker_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_new_file,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_chunk_kind,
    output logic [31:0] o_chunk_length,
    output logic [2:0]  o_status
);
    import pcw_pkg::*;

    logic    push;
    t_result push_rec;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;
    t_result q_rec;

    pcw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_new_file   (i_new_file),
        .i_queue_full (q_full),
        .o_push       (push),
        .o_rec        (push_rec)
    );

    pcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_rec   (q_rec)
    );

    pcw_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_rec        (q_rec),
        .o_q_pop        (q_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_chunk_kind   (o_chunk_kind),
        .o_chunk_length (o_chunk_length),
        .o_status       (o_status)
    );

endmodule

>>> tb/sv/tb_png_chunk_walker_top.sv
// Self-checking testbench for png_chunk_walker_top: directed table, random PNG streams.
`timescale 1ns / 1ps
module tb_png_chunk_walker_top;
    import pcw_pkg::*;

    localparam int RANDOM_ITEMS   = 550;
    localparam int IDLE_PERCENT   = 12;
    localparam int RX_HOLD_CYCLES = 120;
    localparam int STALL_LIMIT    = 1000;
    localparam int DRAIN_CYCLES   = 10;

    localparam logic [63:0] PNG_MAGIC = 64'h89504E470D0A1A0A;

    // One row of the directed table; want is only used when checked is set
    typedef struct packed {
        logic [7:0] b;
        logic       nf;
        logic       checked;
        t_result    want;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_new_file = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [4:0]  o_chunk_kind;
    logic [31:0] o_chunk_length;
    logic [2:0]  o_status;

    // Walker state mirrored by the predictor
    logic [2:0]  walk_phase = PH_SIG;
    logic [2:0]  pos = 3'd0;
    logic [31:0] len_word = 32'd0;
    logic [31:0] tag_word = 32'd0;
    logic [32:0] skip_left = 33'd0;
    logic        hdr_seen = 1'b0;
    logic        bkgd_seen = 1'b0;

    t_result   pending_reports[$];
    t_stim_row plan[$];
    int        mismatches = 0;
    int        fed_items = 0;
    int        quiet_cycles = 0;
    bit        calm = 1'b0;
    bit        hold_req = 1'b0;
    bit        hold_spent = 1'b0;
    bit        pause_done = 1'b0;

    png_chunk_walker_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_new_file     (i_new_file),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_chunk_kind   (o_chunk_kind),
        .o_chunk_length (o_chunk_length),
        .o_status       (o_status)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Four-character tag of each known chunk kind
    function automatic logic [31:0] tag_of(input logic [4:0] k);
        case (k)
            KIND_IHDR: return "IHDR";
            KIND_IEND: return "IEND";
            KIND_IDAT: return "IDAT";
            KIND_PLTE: return "PLTE";
            KIND_BKGD: return "bKGD";
            KIND_CHRM: return "cHRM";
            KIND_GAMA: return "gAMA";
            KIND_ICCP: return "iCCP";
            KIND_SBIT: return "sBIT";
            KIND_SRGB: return "sRGB";
            KIND_HIST: return "hIST";
            KIND_TRNS: return "tRNS";
            KIND_PHYS: return "pHYs";
            KIND_SPLT: return "sPLT";
            KIND_TIME: return "tIME";
            KIND_ITXT: return "iTXt";
            KIND_TEXT: return "tEXt";
            KIND_ZTXT: return "zTXt";
            default:   return 32'd0;
        endcase
    endfunction

    function automatic logic [4:0] kind_of(input logic [31:0] tag);
        int k;
        for (k = 0; k <= KIND_ZTXT; k++)
            if (tag_of(k[4:0]) == tag) return k[4:0];
        return KIND_NONE;
    endfunction

    function automatic t_stim_row byte_row(input logic [7:0] b, input logic nf);
        return '{b: b, nf: nf, checked: 1'b0, want: '0};
    endfunction

    function automatic t_stim_row report_row(input logic [7:0] b, input logic nf,
                                             input logic [4:0] kind, input logic [31:0] len,
                                             input logic [2:0] st);
        return '{b: b, nf: nf, checked: 1'b1, want: '{kind: kind, length: len, status: st}};
    endfunction

    // Append one row to the directed table
    task automatic add_row(input t_stim_row row);
        plan.insert(plan.size(), row);
    endtask

    // Advance the walker by one byte; got is set when the byte yields a report
    task automatic walk_byte(input logic [7:0] b, input logic nf,
                             output bit got, output t_result res);
        logic [4:0] k;
        got = 1'b0;
        res = '0;
        if (nf) begin
            walk_phase = PH_SIG;
            pos        = 3'd0;
            len_word   = 32'd0;
            tag_word   = 32'd0;
            skip_left  = 33'd0;
            hdr_seen   = 1'b0;
            bkgd_seen  = 1'b0;
        end
        case (walk_phase)
            PH_SIG: begin
                if (b != PNG_MAGIC[63 - 8 * int'(pos) -: 8]) begin
                    walk_phase = PH_STOP;
                    got        = 1'b1;
                    res.kind   = KIND_IHDR;
                    res.status = ST_BAD_SIG;
                end else if (pos == 3'd7) begin
                    walk_phase = PH_LEN;
                    pos        = 3'd0;
                    len_word   = 32'd0;
                end else begin
                    pos++;
                end
            end
            PH_LEN: begin
                len_word = {len_word[23:0], b};
                if (pos == 3'd3) begin
                    walk_phase = PH_TYPE;
                    pos        = 3'd0;
                    tag_word   = 32'd0;
                end else begin
                    pos++;
                end
            end
            PH_TYPE: begin
                tag_word = {tag_word[23:0], b};
                if (pos < 3'd3) begin
                    pos++;
                end else begin
                    pos        = 3'd0;
                    k          = kind_of(tag_word);
                    got        = 1'b1;
                    res.kind   = k;
                    res.length = len_word;
                    res.status = ST_OK;
                    if (k == KIND_NONE) begin
                        walk_phase = PH_STOP;
                        res.kind   = KIND_IHDR;
                        res.status = ST_UNKNOWN;
                    end else if (!hdr_seen && k != KIND_IHDR) begin
                        walk_phase = PH_STOP;
                        res.status = ST_NOT_IHDR;
                    end else if (k == KIND_BKGD && bkgd_seen) begin
                        hdr_seen   = 1'b1;
                        walk_phase = PH_STOP;
                        res.status = ST_DUP_BKGD;
                    end else begin
                        hdr_seen = 1'b1;
                        if (k == KIND_BKGD) bkgd_seen = 1'b1;
                        if (k == KIND_IEND) begin
                            walk_phase = PH_STOP;
                        end else begin
                            skip_left  = {1'b0, len_word} + CRC_BYTES;
                            walk_phase = PH_SKIP;
                        end
                    end
                end
            end
            PH_SKIP: begin
                if (skip_left != 33'd0) skip_left--;
                if (skip_left == 33'd0) begin
                    walk_phase = PH_LEN;
                    pos        = 3'd0;
                    len_word   = 32'd0;
                end
            end
            default: ;
        endcase
    endtask

    // Offer one input word, wait for acceptance, then log what it should produce
    task automatic send_byte(input logic [7:0] b, input logic nf,
                             input logic checked, input t_result want);
        int      gap;
        bit      got;
        t_result res;
        gap = 0;
        if (!calm)
            while ($urandom_range(99) < IDLE_PERCENT) gap++;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_new_file  <= nf;
        do @(posedge i_clk); while (!o_ready);
        fed_items++;
        walk_byte(b, nf, got, res);
        if (checked) res = want;
        if (checked || got) begin
            pending_reports.insert(pending_reports.size(), res);
        end
    endtask

    // One random file: mostly well-formed chunk sequences with errors mixed in
    task automatic send_random_file();
        int          i;
        int          c;
        int          n;
        int          roll;
        int          bad_pos;
        int          chunks;
        logic [7:0]  b;
        logic [4:0]  kind;
        logic [31:0] tag;
        logic [31:0] len;
        bit          stops_walk;
        roll    = $urandom_range(99);
        bad_pos = (roll < 8) ? int'($urandom_range(7)) : 8;
        for (i = 0; i < 8 && i <= bad_pos; i++) begin
            b = PNG_MAGIC[63 - 8 * i -: 8];
            if (i == bad_pos) b = b ^ 8'($urandom_range(1, 255));
            send_byte(b, i == 0, 1'b0, '0);
        end
        chunks = (bad_pos < 8) ? 0 : int'($urandom_range(1, 8));
        for (c = 0; c < chunks && walk_phase != PH_STOP; c++) begin
            roll = $urandom_range(99);
            if (c == 0)
                kind = (roll < 8) ? 5'($urandom_range(1, KIND_ZTXT)) : KIND_IHDR;
            else if (c == chunks - 1 && roll < 85)
                kind = KIND_IEND;
            else if (roll < 15)
                kind = KIND_BKGD;
            else
                kind = 5'($urandom_range(0, KIND_ZTXT));
            tag  = tag_of(kind);
            roll = $urandom_range(99);
            if (roll < 3)
                tag = $urandom;
            else if (roll < 6)
                tag = tag ^ (32'd1 << $urandom_range(31));
            kind = kind_of(tag);
            stops_walk = kind == KIND_NONE || kind == KIND_IEND ||
                         (!hdr_seen && kind != KIND_IHDR) || (kind == KIND_BKGD && bkgd_seen);
            // huge lengths only where the walk ends at the header
            if (stops_walk && $urandom_range(1) == 1)
                len = $urandom;
            else if ($urandom_range(19) == 0)
                len = $urandom_range(13, 64);
            else
                len = $urandom_range(0, 6);
            for (i = 3; i >= 0; i--) send_byte(len[8 * i +: 8], 1'b0, 1'b0, '0);
            for (i = 3; i >= 0; i--) send_byte(tag[8 * i +: 8], 1'b0, 1'b0, '0);
            if (!stops_walk) begin
                n = int'(len) + 4;
                // now and then the file is cut short inside the chunk body
                if ($urandom_range(32) == 0) n = int'($urandom_range(0, n - 1));
                for (i = 0; i < n; i++) send_byte(8'($urandom), 1'b0, 1'b0, '0);
                if (n < int'(len) + 4) return;
            end
        end
        // trailing noise, usually ignored by a stopped walker
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0, 1'b0, '0);
    endtask

    task automatic flag_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch on %s at %0t: got %0h, want %0h", field, $time, got, want);
        mismatches++;
    endtask

    // Receiver: random stalls, one long hold-off, calm stretch with no stalls
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_spent) begin
                hold_spent = 1'b1;
                i_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // Compare each accepted result word with the oldest expected report
    always @(posedge i_clk) begin
        t_result head;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_reports.size() == 0) begin
                flag_mismatch("unexpected result kind", 32'(o_chunk_kind), 32'd0);
            end else begin
                head = pending_reports.pop_front();
                if (o_chunk_kind !== head.kind)
                    flag_mismatch("chunk_kind", 32'(o_chunk_kind), 32'(head.kind));
                if (o_chunk_length !== head.length)
                    flag_mismatch("chunk_length", o_chunk_length, head.length);
                if (o_status !== head.status)
                    flag_mismatch("status", 32'(o_status), 32'(head.status));
            end
        end
    end

    // Watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        // Directed table: zero-length IHDR, max-length IEND, stopped byte, bad signature
        add_row(byte_row(8'd137, 1'b1));
        add_row(byte_row(8'd80, 1'b0));
        add_row(byte_row(8'd78, 1'b0));
        add_row(byte_row(8'd71, 1'b0));
        add_row(byte_row(8'd13, 1'b0));
        add_row(byte_row(8'd10, 1'b0));
        add_row(byte_row(8'd26, 1'b0));
        add_row(byte_row(8'd10, 1'b0));
        add_row(byte_row(8'h00, 1'b0));
        add_row(byte_row(8'h00, 1'b0));
        add_row(byte_row(8'h00, 1'b0));
        add_row(byte_row(8'h00, 1'b0));
        add_row(byte_row("I", 1'b0));
        add_row(byte_row("H", 1'b0));
        add_row(byte_row("D", 1'b0));
        add_row(report_row("R", 1'b0, KIND_IHDR, 32'd0, ST_OK));
        add_row(byte_row(8'hFF, 1'b0));
        add_row(byte_row(8'h00, 1'b0));
        add_row(byte_row(8'hFF, 1'b0));
        add_row(byte_row(8'h00, 1'b0));
        add_row(byte_row(8'hFF, 1'b0));
        add_row(byte_row(8'hFF, 1'b0));
        add_row(byte_row(8'hFF, 1'b0));
        add_row(byte_row(8'hFF, 1'b0));
        add_row(byte_row("I", 1'b0));
        add_row(byte_row("E", 1'b0));
        add_row(byte_row("N", 1'b0));
        add_row(report_row("D", 1'b0, KIND_IEND, 32'hFFFF_FFFF, ST_OK));
        add_row(byte_row(8'd137, 1'b0));
        add_row(report_row(8'hFF, 1'b1, KIND_IHDR, 32'd0, ST_BAD_SIG));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[r]) send_byte(plan[r].b, plan[r].nf, plan[r].checked, plan[r].want);

        // Random files until about RANDOM_ITEMS words have gone in
        fed_items = 0;
        while (fed_items < RANDOM_ITEMS) begin
            calm = fed_items >= 250 && fed_items < 330;
            if (fed_items >= 120) hold_req = 1'b1;
            if (!pause_done && fed_items >= 420) begin
                pause_done = 1'b1;
                i_valid <= 1'b0;
                do @(posedge i_clk); while (pending_reports.size() != 0);
            end
            send_random_file();
        end
        i_valid <= 1'b0;

        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/pcw_pkg.sv
rtl/pcw_front.sv
rtl/pcw_queue.sv
rtl/pcw_back.sv
rtl/png_chunk_walker_top.sv
tb/sv/tb_png_chunk_walker_top.sv
